// ----- design/swma_pkg.sv -----
// ----------------------------------------------------------------------------
// swma_pkg: shared types and constants for the sweep angle moving average
// Fixed field widths, angle limits, controller states and the command and
// status words that pass between controller and datapath.
// ----------------------------------------------------------------------------
package swma_pkg;

  localparam int WINDOW_SIZE_DEF = 8;

  localparam int CH_W       = 2;
  localparam int ANGLE_W    = 16;
  localparam int TIME_W     = 32;
  localparam int GAIN_W     = 24;
  localparam int PROD_W     = TIME_W + GAIN_W;
  localparam int GAIN_SHIFT = 24;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 16'd46080;
  localparam logic [GAIN_W-1:0]  GAIN_RESET = 24'd1932735;
  localparam logic [CH_W-1:0]    CH_LAST    = 2'd3;

  localparam logic REQ_SWEEP = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WRITE,
    ST_SEND,
    ST_READ,
    ST_DRAIN,
    ST_DIV_LOAD
  } swma_state_t;

  typedef struct packed {
    logic            capture;
    logic            mul;
    logic            wr;
    logic            acc_clr;
    logic            rd;
    logic            div_load;
    logic            load_out;
    logic            out_read;
    logic            last;
    logic [CH_W-1:0] chan;
  } swma_cmd_t;

  typedef struct packed {
    logic out_free;
  } swma_status_t;

endpackage

// ----- design/swma_ctrl.sv -----
// ----------------------------------------------------------------------------
// swma_ctrl: sequencing state machine
// Accepts one word at a time, steps the datapath through the angle product
// and window write, or through four window sums and divisions on a read.
// ----------------------------------------------------------------------------
module swma_ctrl
  import swma_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         in_req_type,
  output swma_cmd_t    cmd,
  output logic [((WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1)-1:0] rd_idx,
  input  swma_status_t status
);

  localparam int IDX_W   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W   = IDX_W;

  swma_state_t      state_r, state_nxt;
  logic [CH_W-1:0]  chan_r, chan_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             read_r, read_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chan_r  <= '0;
      cnt_r   <= '0;
      read_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
      cnt_r   <= cnt_nxt;
      read_r  <= read_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign rd_idx   = cnt_r[IDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    chan_nxt  = chan_r;
    cnt_nxt   = cnt_r;
    read_nxt  = read_r;
    cmd       = '0;
    cmd.chan  = chan_r;
    cmd.last  = (chan_r == CH_LAST);
    cmd.out_read = read_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.acc_clr = 1'b1;
          chan_nxt    = '0;
          cnt_nxt     = '0;
          read_nxt    = in_req_type;
          state_nxt   = (in_req_type == REQ_READ) ? ST_READ : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_READ: begin
        cmd.rd  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WINDOW_SIZE - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last read word lands in the accumulator here
      ST_DRAIN: begin
        state_nxt = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_SEND;
      end
      ST_SEND: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (!read_r || chan_r == CH_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.acc_clr = 1'b1;
            chan_nxt    = chan_r + 1'b1;
            cnt_nxt     = '0;
            state_nxt   = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted while previous one still in flight");

  a_last_on_fourth: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && cmd.out_read) |-> (cmd.last == (cmd.chan == CH_LAST)))
    else $error("read result marked last on wrong channel");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> status.out_free)
    else $error("output register overwritten");

endmodule

// ----- design/swma_dp.sv -----
// ----------------------------------------------------------------------------
// swma_dp: angle datapath, window memory, accumulator and divider
// Holds the gain register, the four ring windows with their write positions,
// the reciprocal multiply that divides by the window size and the output
// register.
// ----------------------------------------------------------------------------
module swma_dp
  import swma_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [GAIN_W-1:0]   cfg_data,
  input  logic                in_pulse_new,
  input  logic [TIME_W-1:0]   in_pulse_start_time,
  input  logic [TIME_W-1:0]   in_sweep_start_time,
  input  logic                in_station,
  input  logic                in_sweep_axis,
  input  logic                in_dual_lock,
  input  swma_cmd_t           cmd,
  input  logic [((WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1)-1:0] rd_idx,
  output swma_status_t        status,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_accepted,
  output logic                out_station,
  output logic                out_axis,
  output logic [ANGLE_W-1:0]  out_average_angle,
  output logic                out_last
);

  localparam int IDX_W    = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int LOG_W    = $clog2(WINDOW_SIZE);
  localparam int SUM_W    = ANGLE_W + LOG_W;
  localparam int ADDR_W   = CH_W + IDX_W;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int CHANNELS = 1 << CH_W;
  // floor(sum / WINDOW_SIZE) as (sum * RECIP) >> DIV_SH, exact for every sum
  localparam int DIV_SH   = SUM_W + LOG_W;
  localparam int RECIP_W  = SUM_W + 1;
  localparam int QPROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SH)
                                         + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE));

  logic [GAIN_W-1:0]  gain_r;
  logic [TIME_W-1:0]  diff_r;
  logic [CH_W-1:0]    cap_ch_r;
  logic               use_r;
  logic [PROD_W-1:0]  prod_r;

  logic [ANGLE_W-1:0] mem [DEPTH];
  logic [ANGLE_W-1:0] rd_data_r;
  logic               rd_vld_r;
  logic               rd_live_r;

  logic [IDX_W-1:0]   wpos_r [CHANNELS];
  logic [CHANNELS-1:0] full_r;

  logic [SUM_W-1:0]   acc_r;
  logic [ANGLE_W-1:0] quo_r;

  logic               out_valid_r;
  logic               out_accepted_r;
  logic               out_station_r;
  logic               out_axis_r;
  logic [ANGLE_W-1:0] out_average_angle_r;
  logic               out_last_r;

  logic [TIME_W-1:0]  scaled;
  logic [ANGLE_W-1:0] angle;
  logic [IDX_W-1:0]   wr_pos;
  logic [IDX_W-1:0]   rd_pos;
  logic [QPROD_W-1:0] qprod;
  logic               pos_ok;

  // gain register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_valid) begin
      gain_r <= cfg_data;
    end
  end

  // capture and angle product
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      diff_r   <= in_pulse_start_time - in_sweep_start_time;
      cap_ch_r <= {in_station, in_sweep_axis};
      use_r    <= in_pulse_new & in_dual_lock;
    end
    if (cmd.mul) begin
      prod_r <= diff_r * PROD_W'(gain_r);
    end
  end

  assign scaled = prod_r[PROD_W-1:GAIN_SHIFT];
  assign angle  = (scaled > TIME_W'(ANGLE_MAX)) ? ANGLE_MAX : scaled[ANGLE_W-1:0];
  assign wr_pos = wpos_r[cap_ch_r];
  assign rd_pos = wpos_r[cmd.chan];

  // ring write positions; full marks a window whose every entry was written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wpos_r[c] <= '0;
      end
      full_r <= '0;
    end else if (cmd.wr && use_r) begin
      if (wr_pos == IDX_W'(WINDOW_SIZE - 1)) begin
        wpos_r[cap_ch_r] <= '0;
        full_r[cap_ch_r] <= 1'b1;
      end else begin
        wpos_r[cap_ch_r] <= wr_pos + 1'b1;
      end
    end
  end

  // window memory
  always_ff @(posedge clk) begin
    if (cmd.wr && use_r) begin
      mem[{cap_ch_r, wr_pos}] <= angle;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[{cmd.chan, rd_idx}];
    end
  end

  // entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
    end
    if (cmd.rd) begin
      rd_live_r <= full_r[cmd.chan] || (rd_idx < rd_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (rd_vld_r && rd_live_r) begin
      acc_r <= acc_r + SUM_W'(rd_data_r);
    end
  end

  // divide by the window size with one reciprocal multiply
  assign qprod = QPROD_W'(acc_r) * QPROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo_r <= qprod[DIV_SH +: ANGLE_W];
    end
  end

  // output register
  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cmd.out_read) begin
        out_accepted_r      <= 1'b0;
        out_station_r       <= cmd.chan[1];
        out_axis_r          <= cmd.chan[0];
        out_average_angle_r <= quo_r;
        out_last_r          <= cmd.last;
      end else begin
        out_accepted_r      <= use_r;
        out_station_r       <= cap_ch_r[1];
        out_axis_r          <= cap_ch_r[0];
        out_average_angle_r <= '0;
        out_last_r          <= 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_station       = out_station_r;
  assign out_axis          = out_axis_r;
  assign out_average_angle = out_average_angle_r;
  assign out_last          = out_last_r;

  always_comb begin
    pos_ok = 1'b1;
    for (int c = 0; c < CHANNELS; c++) begin
      if (wpos_r[c] > IDX_W'(WINDOW_SIZE - 1)) begin
        pos_ok = 1'b0;
      end
    end
  end

  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n) pos_ok)
    else $error("write position beyond window");

  a_rd_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> rd_vld_r)
    else $error("read data strobe lost");

  a_no_wr_during_rd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr && (cmd.rd || rd_vld_r)))
    else $error("window write overlaps a sum");

endmodule

// ----- design/sweep_angle_moving_average.sv -----
// ----------------------------------------------------------------------------
// sweep_angle_moving_average: sweep angles with a boxcar mean per channel
// Converts sweep hit times to angles, keeps a ring window per station/axis
// and reports the four window means on a read request.
//
//   port group   dir   handshake            contents
//   in_*         in    in_valid/in_stall    request word, sweep sample fields
//   out_*        out   out_valid/out_stall  one word per sweep or channel
//   cfg_*        in    cfg_valid/cfg_ready  angle gain, 24 bit
//
// sweep word: capture, multiply, window write and output load in turn; the
//   32x24 gain multiply is the long path
// read word: capture, then for each channel one memory read per entry,
//   then drain, reciprocal divide and output load
// reset clears write positions and fill flags; no memory clearing pass
// out_stall holds the result register and delays each output load while a
//   held result waits; in_stall is high while busy
// ----------------------------------------------------------------------------
module sweep_angle_moving_average
  import swma_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic               in_pulse_new,
  input  logic [TIME_W-1:0]  in_pulse_start_time,
  input  logic [TIME_W-1:0]  in_sweep_start_time,
  input  logic               in_station,
  input  logic               in_sweep_axis,
  input  logic               in_dual_lock,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic               out_station,
  output logic               out_axis,
  output logic [ANGLE_W-1:0] out_average_angle,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [GAIN_W-1:0]  cfg_data
);

  localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

  swma_cmd_t        cmd;
  swma_status_t     status;
  logic [IDX_W-1:0] rd_idx;

  // gain register takes a write in any cycle
  assign cfg_ready = 1'b1;

  swma_ctrl #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .cmd         (cmd),
    .rd_idx      (rd_idx),
    .status      (status)
  );

  swma_dp #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_data            (cfg_data),
    .in_pulse_new        (in_pulse_new),
    .in_pulse_start_time (in_pulse_start_time),
    .in_sweep_start_time (in_sweep_start_time),
    .in_station          (in_station),
    .in_sweep_axis       (in_sweep_axis),
    .in_dual_lock        (in_dual_lock),
    .cmd                 (cmd),
    .rd_idx              (rd_idx),
    .status              (status),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_accepted        (out_accepted),
    .out_station         (out_station),
    .out_axis            (out_axis),
    .out_average_angle   (out_average_angle),
    .out_last            (out_last)
  );

endmodule

// ----- sim/tb_sweep_angle_moving_average.sv -----
// ----------------------------------------------------------------------------
// tb_sweep_angle_moving_average: self-checking bench for the sweep angle mean
// Runs a short directed table (empty windows, gating, saturation, tick wrap,
// ring wrap), then random sweep and read words under several gain settings.
// Random idle and stall on both sides, except during one steady run. A local
// model of the windows checks every result word in order.
// ----------------------------------------------------------------------------
module tb_sweep_angle_moving_average
  import swma_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS = 4;
  localparam int NW       = WINDOW_SIZE_DEF;
  localparam int LIMIT    = 400000;
  localparam int DRAIN    = 130;

  typedef struct {
    logic              req;
    logic              fresh;
    logic [TIME_W-1:0] pulse_t;
    logic [TIME_W-1:0] sweep_t;
    logic              st;
    logic              ax;
    logic              lock;
  } sweep_word_t;

  typedef struct {
    logic               accepted;
    logic               station;
    logic               axis;
    logic [ANGLE_W-1:0] angle;
    logic               last;
  } avg_word_t;

  typedef struct {
    sweep_word_t        w;
    bit                 typed;
    logic               t_acc;
    logic [ANGLE_W-1:0] t_avg;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_req_type;
  logic               in_pulse_new;
  logic [TIME_W-1:0]  in_pulse_start_time;
  logic [TIME_W-1:0]  in_sweep_start_time;
  logic               in_station;
  logic               in_sweep_axis;
  logic               in_dual_lock;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic               out_accepted;
  logic               out_station;
  logic               out_axis;
  logic [ANGLE_W-1:0] out_average_angle;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [GAIN_W-1:0]  cfg_data;

  // local copy of the windows and the gain
  logic [ANGLE_W-1:0] angle_hist [CHANNELS][NW];
  int                 hist_pos [CHANNELS];
  logic [GAIN_W-1:0]  gain_q;

  avg_word_t avg_expected [$];
  dir_row_t  dir_q [$];
  int        errors = 0;
  int        cycles = 0;
  bit        steady = 1'b0;

  sweep_angle_moving_average u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_pulse_new        (in_pulse_new),
    .in_pulse_start_time (in_pulse_start_time),
    .in_sweep_start_time (in_sweep_start_time),
    .in_station          (in_station),
    .in_sweep_axis       (in_sweep_axis),
    .in_dual_lock        (in_dual_lock),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_accepted        (out_accepted),
    .out_station         (out_station),
    .out_axis            (out_axis),
    .out_average_angle   (out_average_angle),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [ANGLE_W-1:0] tick_angle(input logic [TIME_W-1:0] hit,
                                                    input logic [TIME_W-1:0] start);
    logic [TIME_W-1:0] diff;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    diff = hit - start;  // wraps modulo 2^32
    prod = PROD_W'(diff) * PROD_W'(gain_q);
    quot = prod >> GAIN_SHIFT;
    if (quot > PROD_W'(ANGLE_MAX)) quot = PROD_W'(ANGLE_MAX);
    return quot[ANGLE_W-1:0];
  endfunction

  // updates the windows and queues the result words of one accepted word
  task automatic predict_word(input sweep_word_t w, input bit typed, input logic t_acc,
                              input logic [ANGLE_W-1:0] t_avg);
    int        ch;
    int        sum;
    avg_word_t r;
    logic      acc;
    if (w.req == REQ_SWEEP) begin
      acc = w.fresh && w.lock;
      if (acc) begin
        ch = int'({w.st, w.ax});
        angle_hist[ch][hist_pos[ch]] = tick_angle(w.pulse_t, w.sweep_t);
        hist_pos[ch] = (hist_pos[ch] + 1) % NW;
      end
      r.accepted = typed ? t_acc : acc;
      r.station  = w.st;
      r.axis     = w.ax;
      r.angle    = '0;
      r.last     = 1'b1;
      avg_expected.push_back(r);
    end else begin
      for (ch = 0; ch < CHANNELS; ch++) begin
        sum = 0;
        for (int i = 0; i < NW; i++) sum += angle_hist[ch][i];
        r.accepted = 1'b0;
        r.station  = ch[1];
        r.axis     = ch[0];
        r.angle    = typed ? t_avg : ANGLE_W'(sum / NW);
        r.last     = (ch == CHANNELS - 1);
        avg_expected.push_back(r);
      end
    end
  endtask

  task automatic send_word(input sweep_word_t w, input bit typed, input logic t_acc,
                           input logic [ANGLE_W-1:0] t_avg);
    if (!steady) begin
      while ($urandom_range(99) < 27) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid            <= 1'b1;
    in_req_type         <= w.req;
    in_pulse_new        <= w.fresh;
    in_pulse_start_time <= w.pulse_t;
    in_sweep_start_time <= w.sweep_t;
    in_station          <= w.st;
    in_sweep_axis       <= w.ax;
    in_dual_lock        <= w.lock;
    do @(posedge clk); while (in_stall);
    predict_word(w, typed, t_acc, t_avg);
  endtask

  // sender holds off until every result is back, then the gain is written
  task automatic set_gain(input logic [GAIN_W-1:0] value);
    in_valid <= 1'b0;
    while (avg_expected.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gain_q = value;
  endtask

  function automatic sweep_word_t random_word();
    sweep_word_t       w;
    logic [TIME_W-1:0] diff;
    w.req     = ($urandom_range(99) < 20) ? REQ_READ : REQ_SWEEP;
    w.fresh   = ($urandom_range(99) < 88);
    w.lock    = ($urandom_range(99) < 88);
    w.st      = 1'($urandom_range(1));
    w.ax      = 1'($urandom_range(1));
    w.sweep_t = $urandom;
    case ($urandom_range(2))
      0:       diff = $urandom_range(4095);
      1:       diff = $urandom_range(450000);
      default: diff = $urandom;
    endcase
    w.pulse_t = w.sweep_t + diff;
    return w;
  endfunction

  task automatic run_random(input int n);
    repeat (n) send_word(random_word(), 1'b0, 1'b0, '0);
  endtask

  task automatic add_row(input logic req, input logic fresh, input logic [TIME_W-1:0] pulse_t,
                         input logic [TIME_W-1:0] sweep_t, input logic st, input logic ax,
                         input logic lock, input bit typed, input logic t_acc,
                         input logic [ANGLE_W-1:0] t_avg);
    dir_row_t row;
    row.w.req     = req;
    row.w.fresh   = fresh;
    row.w.pulse_t = pulse_t;
    row.w.sweep_t = sweep_t;
    row.w.st      = st;
    row.w.ax      = ax;
    row.w.lock    = lock;
    row.typed     = typed;
    row.t_acc     = t_acc;
    row.t_avg     = t_avg;
    dir_q.push_back(row);
  endtask

  task automatic check_word();
    avg_word_t e;
    if (avg_expected.size() == 0) begin
      $error("unexpected word: station %0d axis %0d angle %0d", out_station, out_axis,
             out_average_angle);
      errors++;
    end else begin
      e = avg_expected.pop_front();
      if (out_accepted !== e.accepted) begin
        $error("out_accepted: expected %0d, got %0d", e.accepted, out_accepted);
        errors++;
      end
      if (out_station !== e.station) begin
        $error("out_station: expected %0d, got %0d", e.station, out_station);
        errors++;
      end
      if (out_axis !== e.axis) begin
        $error("out_axis: expected %0d, got %0d", e.axis, out_axis);
        errors++;
      end
      if (out_average_angle !== e.angle) begin
        $error("out_average_angle: expected %0d, got %0d", e.angle, out_average_angle);
        errors++;
      end
      if (out_last !== e.last) begin
        $error("out_last: expected %0d, got %0d", e.last, out_last);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_word();
    out_stall <= !steady && ($urandom_range(99) < 27);
  end

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_req_type         = REQ_SWEEP;
    in_pulse_new        = 1'b0;
    in_pulse_start_time = '0;
    in_sweep_start_time = '0;
    in_station          = 1'b0;
    in_sweep_axis       = 1'b0;
    in_dual_lock        = 1'b0;
    cfg_valid           = 1'b0;
    cfg_data            = '0;
    gain_q              = GAIN_RESET;
    foreach (angle_hist[c, i]) angle_hist[c][i] = '0;
    foreach (hist_pos[c]) hist_pos[c] = 0;

    // empty windows read as zero
    add_row(REQ_READ,  1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0);
    // gating on new and lock
    add_row(REQ_SWEEP, 1'b0, 32'd5000, '0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, '0);
    add_row(REQ_SWEEP, 1'b1, 32'd5000, '0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, '0);
    add_row(REQ_SWEEP, 1'b0, '1, '1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, '0);
    // one hit per channel: plain, saturated, tick wrap, zero difference; then a wrapped hit and a read
    add_row(REQ_SWEEP, 1'b1, 32'd1000, '0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, '0);
    add_row(REQ_SWEEP, 1'b1, '1, '0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, '0);
    add_row(REQ_SWEEP, 1'b1, 32'd100, 32'hFFFF_FF00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, '0);
    add_row(REQ_SWEEP, 1'b1, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, '0);
    add_row(REQ_SWEEP, 1'b1, '0, 32'd1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, '0);
    add_row(REQ_READ,  1'b1, '1, '1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, '0);
    // fill one window past the ring end with full-scale angles
    repeat (NW) add_row(REQ_SWEEP, 1'b1, '1, '0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, '0);
    add_row(REQ_READ,  1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(REQ_SWEEP, 1'b1, 32'h5A5A_5A5A, 32'h1234_5678, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_q[k]) send_word(dir_q[k].w, dir_q[k].typed, dir_q[k].t_acc, dir_q[k].t_avg);

    set_gain('1);
    steady = 1'b1;
    run_random(30);
    steady = 1'b0;
    set_gain('0);
    run_random(15);
    set_gain(GAIN_W'($urandom));
    run_random(25);
    set_gain(GAIN_RESET);
    run_random(30);

    in_valid <= 1'b0;
    while (avg_expected.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
